@@ rtl/core/poaf_pkg.sv @@
// package: store geometry, register map and binary32 constants for the overlap-add block
`default_nettype none
package poaf_pkg;
  localparam int MAX_CHANNELS = 1024;
  localparam int MAX_PHASES   = 8;
  localparam int CH_W    = $clog2(MAX_CHANNELS);
  localparam int PH_W    = $clog2(MAX_PHASES);
  localparam int DEPTH   = MAX_CHANNELS * MAX_PHASES;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CC_W    = 11;
  localparam int PC_W    = 4;
  localparam int PADDR_W = 3;

  localparam logic [PADDR_W-3:0] REG_CHANNEL_COUNT = 1'b0;
  localparam logic [PADDR_W-3:0] REG_PHASE_COUNT   = 1'b1;

  localparam logic [CC_W-1:0] CC_RESET = 11'd1;
  localparam logic [PC_W-1:0] PC_RESET = 4'd2;
  localparam logic [CC_W-1:0] CC_LIMIT = 11'd1024;

  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
  localparam logic [31:0] POS_INF   = 32'h7F80_0000;
endpackage
`default_nettype wire

@@ rtl/core/poaf_ram.sv @@
// generic single-write, single-read ram with registered read data
`default_nettype none
module poaf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/poaf_fp_add.sv @@
// two-stage binary32 adder: align, then add, normalise and round to nearest even
`default_nettype none
module poaf_fp_add (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [31:0] y
);
  import poaf_pkg::*;

  function automatic logic [4:0] lzc27(input logic [26:0] v);
    logic [4:0] n;
    logic       found;
    n = 5'd27;
    found = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 5'(26 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // stage a: unpack, order by magnitude, align the smaller operand
  logic        a_big;
  logic [31:0] big, sml;
  logic [7:0]  eb, es;
  logic [26:0] mb27, ms27;
  logic [7:0]  diff;
  logic [4:0]  dcap;
  logic [53:0] wide;
  logic [26:0] ms_al;
  logic        nan_a, nan_b, inf_a, inf_b;
  logic        spec_c;
  logic [31:0] spec_val_c;

  always_comb begin
    a_big = a[30:0] >= b[30:0];
    big   = a_big ? a : b;
    sml   = a_big ? b : a;
    eb    = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es    = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    mb27  = {big[30:23] != 8'd0, big[22:0], 3'b000};
    ms27  = {sml[30:23] != 8'd0, sml[22:0], 3'b000};
    diff  = eb - es;
    dcap  = (diff > 8'd27) ? 5'd27 : diff[4:0];
    wide  = {ms27, 27'd0} >> dcap;
    ms_al = {wide[53:28], wide[27] | (|wide[26:0])};
    nan_a = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    nan_b = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    inf_a = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    inf_b = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    spec_c     = nan_a || nan_b || inf_a || inf_b;
    spec_val_c = CANON_NAN;
    if (!nan_a && !nan_b) begin
      if (inf_a && inf_b) begin
        spec_val_c = (a[31] == b[31]) ? (POS_INF | {a[31], 31'd0}) : CANON_NAN;
      end else if (inf_a) begin
        spec_val_c = POS_INF | {a[31], 31'd0};
      end else begin
        spec_val_c = POS_INF | {b[31], 31'd0};
      end
    end
  end

  logic        sa_sgn, sa_sub, sa_spec;
  logic [7:0]  sa_e;
  logic [26:0] sa_mb, sa_ms;
  logic [31:0] sa_spec_val;

  always_ff @(posedge clk) begin
    if (en) begin
      sa_sgn      <= big[31];
      sa_sub      <= a[31] ^ b[31];
      sa_e        <= eb;
      sa_mb       <= mb27;
      sa_ms       <= ms_al;
      sa_spec     <= spec_c;
      sa_spec_val <= spec_val_c;
    end
  end

  // stage b: add or subtract, normalise, round, pack
  logic [27:0] sum;
  logic [26:0] m, mn;
  logic [8:0]  e, en_e;
  logic [4:0]  lz, sh;
  logic [8:0]  lim;
  logic [7:0]  efield;
  logic        up;
  logic [30:0] packed_mag;
  logic [31:0] y_c;

  always_comb begin
    sum = sa_sub ? ({1'b0, sa_mb} - {1'b0, sa_ms}) : ({1'b0, sa_mb} + {1'b0, sa_ms});
    lz  = 5'd0;
    lim = 9'd0;
    sh  = 5'd0;
    if (sum[27]) begin
      m = {sum[27:2], sum[1] | sum[0]};
      e = {1'b0, sa_e} + 9'd1;
    end else begin
      lz  = lzc27(sum[26:0]);
      lim = {1'b0, sa_e} - 9'd1;
      sh  = ({4'd0, lz} < lim) ? lz : lim[4:0];
      m   = sum[26:0] << sh;
      e   = {1'b0, sa_e} - {4'd0, sh};
    end
    mn     = m;
    en_e   = e;
    efield = mn[26] ? en_e[7:0] : 8'd0;
    up     = mn[2] && (mn[1] || mn[0] || mn[3]);
    packed_mag = {efield, mn[25:3]} + {30'd0, up};
    if (sa_spec) begin
      y_c = sa_spec_val;
    end else if (sum == 28'd0) begin
      y_c = {sa_sub ? 1'b0 : sa_sgn, 31'd0};
    end else if (en_e >= 9'd255) begin
      y_c = POS_INF | {sa_sgn, 31'd0};
    end else begin
      y_c = {sa_sgn, packed_mag};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y <= y_c;
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/phase_overlap_add_fp32.sv @@
// top level: overlap-add finish with carry history store and two chained fp32 adders
// throughput: one item per cycle while the master side accepts and the clearing pass is done; the carry store
//   does at most one read and one write each cycle. reset: synchronous, clears control state and configuration
//   registers, then a clearing pass zeroes every carry store entry, during which s_tready stays low
// a stalled master side holds the whole pipeline, nothing is dropped or repeated
`default_nettype none
module phase_overlap_add_fp32 (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // apb configuration port
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [poaf_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  // slave side
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  // channel[9:0], phase[12:10], cur_value[44:13], carry_value[76:45],
  // channel_bias[108:77], zero fill[111:109]
  input  wire logic [111:0]               s_tdata,
  // mode[0]
  input  wire logic [0:0]                 s_tuser,
  // master side
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  // result_value[31:0]
  output logic      [31:0]                m_tdata,
  // error[0]
  output logic      [0:0]                 m_tuser
);
  import poaf_pkg::*;

  // ---- configuration registers
  logic [CC_W-1:0] channel_count;
  logic [PC_W-1:0] phase_count;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= CC_RESET;
      phase_count   <= PC_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[PADDR_W-1:2])
        REG_CHANNEL_COUNT: channel_count <= pwdata[CC_W-1:0];
        REG_PHASE_COUNT:   phase_count   <= pwdata[PC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[PADDR_W-1:2])
      REG_CHANNEL_COUNT: prdata = {{(32-CC_W){1'b0}}, channel_count};
      REG_PHASE_COUNT:   prdata = {{(32-PC_W){1'b0}}, phase_count};
      default:           prdata = 32'd0;
    endcase
  end

  // stride and channel count are legal
  logic cfg_ok;
  always_comb begin
    cfg_ok = (phase_count == 4'd2 || phase_count == 4'd5 || phase_count == 4'd6 ||
              phase_count == 4'd8) && (channel_count != '0) && (channel_count <= CC_LIMIT);
  end

  // ---- clearing pass after reset
  logic [ADDR_W:0] clr_cnt;
  logic            clr_done;
  assign clr_done = clr_cnt[ADDR_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (!clr_done) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // ---- input unpack
  logic [CH_W-1:0]   in_ch;
  logic [PH_W-1:0]   in_ph;
  logic [31:0]       in_cur, in_carry, in_bias;
  logic              in_mode, in_err;
  logic [ADDR_W-1:0] in_addr;

  assign in_ch    = s_tdata[CH_W-1:0];
  assign in_ph    = s_tdata[CH_W+PH_W-1:CH_W];
  assign in_cur   = s_tdata[44:13];
  assign in_carry = s_tdata[76:45];
  assign in_bias  = s_tdata[108:77];
  assign in_mode  = s_tuser[0];
  // entry index is channel * MAX_PHASES + phase
  assign in_addr  = {in_ch, in_ph};
  assign in_err   = !(cfg_ok && ({1'b0, in_ch} < channel_count) &&
                      ({1'b0, in_ph} < phase_count));

  // pipeline advances whenever the output register can move
  logic adv, in_xfer;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv && clr_done;
  assign in_xfer  = s_tvalid && s_tready;

  // ---- stage 1: carry store read data arrives, write of new carry
  logic              v1, mode1, err1, byp1;
  logic [ADDR_W-1:0] addr1;
  logic [31:0]       cur1, carry1, bias1, fwd1;
  logic [31:0]       rd1, stored1;
  logic              we1;

  assign we1     = v1 && !err1;
  assign stored1 = byp1 ? fwd1 : rd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode1  <= in_mode;
      err1   <= in_err;
      addr1  <= in_addr;
      cur1   <= in_cur;
      carry1 <= in_carry;
      bias1  <= in_bias;
      // the item ahead writes the same entry in this cycle: take its carry
      byp1   <= we1 && (addr1 == in_addr);
      fwd1   <= carry1;
    end
  end

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [31:0]       ram_wdata;

  always_comb begin
    if (!clr_done) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt[ADDR_W-1:0];
      ram_wdata = 32'd0;
    end else begin
      ram_we    = we1 && adv;
      ram_waddr = addr1;
      ram_wdata = carry1;
    end
  end

  poaf_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (adv),
    .raddr(in_addr),
    .rdata(rd1)
  );

  // ---- stages 2 to 5: two chained adders, side data delayed alongside
  logic        v2, v3, v4, v5;
  logic        mode2, mode3, mode4, mode5;
  logic        err2, err3, err4, err5;
  logic [31:0] st2, st3, st4, st5;
  logic [31:0] bias2, bias3;
  logic [31:0] sum1, sum2;

  poaf_fp_add u_add1 (.clk(clk), .en(adv), .a(cur1), .b(stored1), .y(sum1));
  poaf_fp_add u_add2 (.clk(clk), .en(adv), .a(sum1), .b(bias3), .y(sum2));

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode2 <= mode1; mode3 <= mode2; mode4 <= mode3; mode5 <= mode4;
      err2  <= err1;  err3  <= err2;  err4  <= err3;  err5  <= err4;
      st2   <= stored1; st3 <= st2; st4 <= st3; st5 <= st4;
      bias2 <= bias1; bias3 <= bias2;
    end
  end

  // ---- output
  assign m_tvalid   = v5;
  assign m_tuser[0] = err5;
  always_comb begin
    if (err5) begin
      m_tdata = 32'd0;
    end else if (mode5) begin
      m_tdata = st5;
    end else begin
      m_tdata = sum2;
    end
  end

  // ---- checks
  a_no_xfer_in_clear: assert property (@(posedge clk) disable iff (rst)
    !clr_done |-> !v1 && !in_xfer)
    else $error("transfer during carry store clearing");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == 32'd0)
    else $error("error result carries nonzero data");

  a_no_store_on_err: assert property (@(posedge clk) disable iff (rst)
    clr_done && v1 && err1 |-> !ram_we)
    else $error("carry store written by a rejected item");

  a_bypass_valid: assert property (@(posedge clk) disable iff (rst)
    adv && in_xfer && we1 && addr1 == in_addr |=> byp1 && fwd1 == $past(carry1))
    else $error("missed forward of adjacent carry write");
endmodule
`default_nettype wire

@@ test/tb_phase_overlap_add_fp32.sv @@
// testbench for the fp32 overlap-add finish block: directed table, random streams, self-checking
`timescale 1ns / 100ps
`default_nettype none
module tb_phase_overlap_add_fp32;
  import poaf_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;   // quiet cycles allowed, must outlast the clearing pass after reset
  localparam int SETTLE_CYCLES  = 20;      // margin after the last result so the pipeline empties

  typedef struct packed {
    logic        mode;     // 0 sample, 1 history access
    logic [9:0]  chan;
    logic [2:0]  ph;
    logic [31:0] cur;
    logic [31:0] carry;
    logic [31:0] bias;
  } sample_t;

  typedef struct packed {
    logic [31:0] value;
    logic        err;
  } sum_t;

  typedef struct packed {
    sample_t     s;
    logic        typed;    // expectation written in the row
    logic [31:0] exp_value;
    logic        exp_err;
  } row_t;

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic s_tvalid, s_tready;
  logic [111:0] s_tdata;   // channel[9:0], phase[12:10], cur[44:13], carry[76:45], bias[108:77]
  logic [0:0] s_tuser;     // mode[0]
  logic m_tvalid, m_tready;
  logic [31:0] m_tdata;    // result_value[31:0]
  logic [0:0] m_tuser;     // error[0]

  phase_overlap_add_fp32 u_top (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser
  );

  // shadow of the block state
  logic [31:0] carry_hist [DEPTH];
  logic [CC_W-1:0] chan_cnt;
  logic [PC_W-1:0] stride;

  sum_t pending_sums[$];
  int   fails = 0;
  int   n_sent = 0, n_got = 0, n_err = 0, n_nan = 0;
  logic idle_en = 1'b1;
  int   quiet = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // binary32 add, round to nearest even, subnormals kept, nan made canonical
  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] x, y, t;
    logic sx, sy;
    int ex, ey, d, e;
    logic [23:0] mx, my;
    logic [27:0] wx, wy, s;
    logic [24:0] m;
    x = a;
    y = b;
    if ((a[30:23] == 8'hFF && a[22:0] != 0) || (b[30:23] == 8'hFF && b[22:0] != 0))
      return CANON_NAN;
    if (a[30:0] == POS_INF[30:0]) begin
      if (b[30:0] == POS_INF[30:0] && a[31] != b[31]) return CANON_NAN;
      return a;
    end
    if (b[30:0] == POS_INF[30:0]) return b;
    if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'b0};
    if (a[30:0] == 0) return b;
    if (b[30:0] == 0) return a;
    if (y[30:0] > x[30:0]) begin
      t = x; x = y; y = t;
    end
    sx = x[31];
    sy = y[31];
    ex = (x[30:23] == 0) ? 1 : int'(x[30:23]);
    ey = (y[30:23] == 0) ? 1 : int'(y[30:23]);
    mx = {x[30:23] != 0, x[22:0]};
    my = {y[30:23] != 0, y[22:0]};
    d  = ex - ey;
    wx = {1'b0, mx, 3'b0};
    wy = {1'b0, my, 3'b0};
    // align the smaller operand, keeping a sticky bit
    if (d >= 27) wy = (my != 0) ? 28'd1 : 28'd0;
    else if (d > 0) wy = (wy >> d) | 28'((wy & ((28'd1 << d) - 1)) != 0);
    e = ex;
    if (sx == sy) begin
      s = wx + wy;
      if (s[27]) begin
        s = (s >> 1) | 28'(s[0]);
        e++;
      end
    end else begin
      s = wx - wy;
      if (s == 0) return 32'h0;
      while (!s[26] && e > 1) begin
        s = s << 1;
        e--;
      end
    end
    m = {1'b0, s[26:3]};
    if (s[2] && (s[1] | s[0] | s[3])) m = m + 1;
    if (m[24]) begin
      m = m >> 1;
      e++;
    end
    if (e >= 255) return {sx, 8'hFF, 23'b0};
    return {sx, m[23] ? e[7:0] : 8'h00, m[22:0]};
  endfunction

  // works out the result of one accepted item and updates the shadow history
  function automatic sum_t overlap_add(input sample_t s);
    sum_t r;
    int idx;
    logic ok;
    ok = (stride == 2 || stride == 5 || stride == 6 || stride == 8) &&
         chan_cnt >= 1 && chan_cnt <= CC_LIMIT &&
         {1'b0, s.chan} < chan_cnt && {1'b0, s.ph} < stride;
    r = '{value: 32'h0, err: 1'b1};
    if (ok) begin
      idx = int'(s.chan) * MAX_PHASES + int'(s.ph);
      r.err = 1'b0;
      r.value = s.mode ? carry_hist[idx] : fp_add(fp_add(s.cur, carry_hist[idx]), s.bias);
      carry_hist[idx] = s.carry;
    end
    return r;
  endfunction

  // result side: random back-pressure and in-order compare
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_got++;
        if (pending_sums.size() == 0) begin
          $display("%0t: result with nothing expected: value %h error %b",
                   $time, m_tdata, m_tuser);
          fails++;
        end else begin
          if (m_tdata !== pending_sums[0].value || m_tuser[0] !== pending_sums[0].err) begin
            $display("%0t: expected value %h error %b, got value %h error %b", $time,
                     pending_sums[0].value, pending_sums[0].err, m_tdata, m_tuser);
            fails++;
          end
          if (m_tuser[0]) n_err++;
          if (m_tdata == CANON_NAN) n_nan++;
          void'(pending_sums.pop_front());
        end
      end
      m_tready <= idle_en ? ($urandom_range(99) >= 10) : 1'b1;
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("phase_overlap_add_fp32: mismatch");
      $finish;
    end
  end

  // one transfer on the slave side, with random idle cycles in front when idle cycles are enabled
  task automatic send_item(input sample_t s, input logic typed, input sum_t typed_sum);
    sum_t r;
    while (idle_en && $urandom_range(99) < 10) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= s.mode;
    s_tdata  <= {3'b0, s.bias, s.carry, s.cur, s.ph, s.chan};
    do @(posedge clk); while (!s_tready);
    r = overlap_add(s);
    pending_sums.push_back(typed ? typed_sum : r);
    n_sent++;
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb write, setup then access; register changes at the access edge
  task automatic write_reg(input logic [PADDR_W-3:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (idx == REG_CHANNEL_COUNT) chan_cnt = val[CC_W-1:0];
    else stride = val[PC_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // binary32 patterns biased towards extremes, subnormals, specials and nearby exponents
  function automatic logic [31:0] pick_float();
    logic [7:0] ex;
    logic [22:0] fr;
    if ($urandom_range(1) == 0) return $urandom;
    case ($urandom_range(5))
      0: ex = 8'h00;
      1: ex = 8'hFF;
      2: ex = 8'hFE;
      3: ex = 8'h01;
      default: ex = 8'($urandom_range(134, 120));
    endcase
    fr = ($urandom_range(3) == 0) ? 23'h0 : 23'($urandom);
    return {1'($urandom), ex, fr};
  endfunction

  function automatic sample_t pick_item();
    sample_t s;
    int lim_c, lim_p;
    lim_c = (chan_cnt >= 1 && chan_cnt <= CC_LIMIT) ? int'(chan_cnt) : 1024;
    lim_p = (stride >= 1 && stride <= 8) ? int'(stride) : 8;
    s.mode = ($urandom_range(3) == 0);
    if ($urandom_range(99) < 88) begin
      // well-formed: in range, often on a few hot channels so carries chain
      s.chan = ($urandom_range(1) == 0) ? 10'($urandom_range((lim_c < 4 ? lim_c : 4) - 1))
                                         : 10'($urandom_range(lim_c - 1));
      s.ph   = 3'($urandom_range(lim_p - 1));
    end else begin
      s.chan = 10'($urandom);
      s.ph   = 3'($urandom);
    end
    s.cur   = pick_float();
    s.carry = pick_float();
    s.bias  = ($urandom_range(7) == 0) ? {~s.cur[31], s.cur[30:0]} : pick_float();
    return s;
  endfunction

  // directed rows, with reset registers: one channel, stride two
  row_t dir_rows[] = '{
    // history read after reset returns zero
    '{'{1'b1, 10'd0, 3'd0, 32'h0, 32'h3F80_0000, 32'h0}, 1'b1, 32'h0, 1'b0},
    '{'{1'b0, 10'd0, 3'd0, 32'h4000_0000, 32'h7F7F_FFFF, 32'h0}, 1'b0, 32'h0, 1'b0},
    // infinity minus infinity
    '{'{1'b0, 10'd0, 3'd1, 32'h7F80_0000, 32'h0, 32'hFF80_0000}, 1'b1, CANON_NAN, 1'b0},
    // channel and phase out of range
    '{'{1'b0, 10'd1, 3'd0, 32'h3F80_0000, 32'h1, 32'h0}, 1'b1, 32'h0, 1'b1},
    '{'{1'b1, 10'd0, 3'd2, 32'h0, 32'hFFFF_FFFF, 32'h0}, 1'b1, 32'h0, 1'b1},
    '{'{1'b0, 10'd1023, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, 32'h0, 1'b1},
    // overflow to infinity
    '{'{1'b0, 10'd0, 3'd0, 32'h7F7F_FFFF, 32'h0000_0001, 32'h7F7F_FFFF}, 1'b0, 32'h0, 1'b0},
    // subnormals
    '{'{1'b0, 10'd0, 3'd1, 32'h0000_0001, 32'h807F_FFFF, 32'h8000_0001}, 1'b0, 32'h0, 1'b0},
    '{'{1'b1, 10'd0, 3'd1, 32'h0, 32'hFFFF_FFFF, 32'h0}, 1'b0, 32'h0, 1'b0},
    // stored nan carry comes back canonical
    '{'{1'b0, 10'd0, 3'd1, 32'h0, 32'h8000_0000, 32'h0}, 1'b1, CANON_NAN, 1'b0},
    // negative zeros, then near cancellation
    '{'{1'b0, 10'd0, 3'd1, 32'h8000_0000, 32'h0, 32'h8000_0000}, 1'b0, 32'h0, 1'b0},
    '{'{1'b0, 10'd0, 3'd0, 32'h3F80_0001, 32'h0, 32'hBF80_0000}, 1'b0, 32'h0, 1'b0}
  };

  // register settings per random phase, bad ones included
  logic [CC_W-1:0] cc_set[] = '{11'd1024, 11'd1, 11'd1024, 11'd3, 11'd0, 11'd1025,
                                11'd2047, 11'd512, 11'd1024, 11'd1024, 11'd17, 11'd1024};
  logic [PC_W-1:0] pc_set[] = '{4'd8, 4'd2, 4'd5, 4'd6, 4'd8, 4'd8,
                                4'd15, 4'd3, 4'd4, 4'd7, 4'd8, 4'd0};

  initial begin
    sum_t typed_sum;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
    for (int i = 0; i < DEPTH; i++) carry_hist[i] = 32'h0;
    chan_cnt = CC_RESET;
    stride   = PC_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      typed_sum = '{value: dir_rows[i].exp_value, err: dir_rows[i].exp_err};
      send_item(dir_rows[i].s, dir_rows[i].typed, typed_sum);
    end
    drain();

    foreach (cc_set[p]) begin
      write_reg(REG_CHANNEL_COUNT, 32'(cc_set[p]));
      write_reg(REG_PHASE_COUNT, 32'(pc_set[p]));
      idle_en = (p != 2);   // one whole phase without idle cycles on either side
      for (int k = 0; k < 108; k++) begin
        if (p == 0 && k == 50) begin
          // hold off the sender until the pipeline is empty
          drain();
        end
        send_item(pick_item(), 1'b0, '0);
      end
      drain();
    end
    idle_en = 1'b1;

    $display("sent %0d items over %0d register settings, %0d results checked", n_sent,
             cc_set.size() + 1, n_got);
    $display("error results %0d, canonical nan results %0d", n_err, n_nan);
    if (fails == 0 && pending_sums.size() == 0) begin
      $display("phase_overlap_add_fp32: match");
    end else begin
      $display("phase_overlap_add_fp32: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire
